### src/mqtt_control_packet_parser_defines.svh
// Assertion macros for the MQTT control packet parser.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef MQTT_CONTROL_PACKET_PARSER_DEFINES_SVH
`define MQTT_CONTROL_PACKET_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define MQP_ASSERT_IMPL(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MQP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MQP_ASSERT_IMPL(lbl, clk, rst, prop, msg)
`define MQP_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### src/mqp_pkg.sv
// Shared types and constants for the MQTT control packet parser.
// No dependencies.
package mqp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [3:0]  packet_type;
    logic [3:0]  packet_flags;
    logic [27:0] remaining_length;
    logic [15:0] field_value;
    logic [3:0]  field_kind;
    logic [1:0]  error_kind;
    logic        packet_done;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_HDR = 4'd0, PH_LEN = 4'd1, PH_SKIP = 4'd2, PH_CFLAGS = 4'd3, PH_HI = 4'd4,
    PH_LO = 4'd5, PH_STR = 4'd6, PH_PAY = 4'd7, PH_QOS = 4'd8, PH_TRAIL = 4'd9
  } phase_t;

  localparam logic [3:0] EV_HDR = 4'd0, EV_LEN = 4'd1, EV_SKIP = 4'd2,
    EV_CFLAGS = 4'd3, EV_HI = 4'd4, EV_LO = 4'd5, EV_STR = 4'd6, EV_PAY = 4'd7,
    EV_QOS = 4'd8, EV_ERR = 4'd9;

  localparam logic [3:0] FK_NONE = 4'd0, FK_PID = 4'd1, FK_KEEP = 4'd2,
    FK_CID = 4'd3, FK_WTOP = 4'd4, FK_WMSG = 4'd5, FK_USER = 4'd6,
    FK_PASS = 4'd7, FK_TOPIC = 4'd8;

  localparam logic [1:0] ER_NONE = 2'd0, ER_LEN = 2'd1, ER_TYPE = 2'd2,
    ER_OVER = 2'd3;

  localparam logic [3:0] PT_CONNECT = 4'd1, PT_PUBLISH = 4'd3, PT_PUBREL = 4'd6,
    PT_SUBSCRIBE = 4'd8, PT_UNSUB = 4'd10;

  // item handed from front to back: byte plus packet-start flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } q_item_t;

  function automatic logic type_supported(input logic [3:0] t);
    case (t) inside
      4'd1, 4'd3, [4'd4:4'd8], 4'd10, [4'd12:4'd14]: type_supported = 1'b1;
      default: type_supported = 1'b0;
    endcase
  endfunction

endpackage

### src/mqp_fifo.sv
// Short queue between the parser front and back; two-entry register FIFO.
// Depends on mqp_pkg.
`include "mqtt_control_packet_parser_defines.svh"
module mqp_fifo (
  input  logic             clk,
  input  logic             rst,
  input  mqp_pkg::q_item_t wr_data,
  input  logic             wr_valid,
  output logic             wr_ready,
  output mqp_pkg::q_item_t rd_data,
  output logic             rd_valid,
  input  logic             rd_ready
);
  import mqp_pkg::*;

  q_item_t    mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) wptr <= ~wptr;
      if (do_rd) rptr <= ~rptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  `MQP_ASSERT_NEVER(a_fifo_over, clk, rst, count == 2'd3, "fifo count out of range")
  `MQP_ASSERT_IMPL(a_fifo_cnt, clk, rst, (do_wr && !do_rd) |=> count == $past(count) + 2'd1, "fifo count did not rise")
  `MQP_ASSERT_IMPL(a_fifo_ptr, clk, rst, (count == 2'd0) |-> (wptr == rptr), "fifo pointers differ when empty")
endmodule

### src/mqp_back.sv
// Back part: per-byte parse state machine, one result per byte into an output register.
// Depends on mqp_pkg.
`include "mqtt_control_packet_parser_defines.svh"
module mqp_back #(
  parameter int MAX_LENGTH_BYTES   = 4,
  parameter int CONNECT_SKIP_BYTES = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  mqp_pkg::q_item_t  in_data,
  input  logic              in_valid,
  output logic              in_ready,
  output mqp_pkg::out_item_t out_data,
  output logic              out_valid,
  input  logic              out_ready
);
  import mqp_pkg::*;

  phase_t      phase, phase_next;
  logic [27:0] bytes_left, bytes_left_next;
  logic [2:0]  len_cnt, len_cnt_next;
  logic [3:0]  cur_type, cur_type_next, cur_flags, cur_flags_next;
  logic [7:0]  cflags, cflags_next, hi_hold, hi_hold_next;
  logic [15:0] str_left, str_left_next;
  logic [3:0]  cur_field, cur_field_next, skip_cnt, skip_cnt_next;
  logic [27:0] len_acc, len_acc_next;
  out_item_t   res;
  logic        take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR; bytes_left <= '0; len_cnt <= '0; cur_type <= '0;
      cur_flags <= '0; cflags <= '0; str_left <= '0; cur_field <= '0;
      hi_hold <= '0; skip_cnt <= '0; len_acc <= '0; out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next; bytes_left <= bytes_left_next; len_cnt <= len_cnt_next;
        cur_type <= cur_type_next; cur_flags <= cur_flags_next; cflags <= cflags_next;
        str_left <= str_left_next; cur_field <= cur_field_next; hi_hold <= hi_hold_next;
        skip_cnt <= skip_cnt_next; len_acc <= len_acc_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data <= res;
  end

  always_comb begin
    logic [7:0]  b;
    logic [3:0]  ev, kind, nxt_field;
    logic [15:0] val;
    logic [1:0]  err;
    logic        end_ok, fin;
    logic [6:0]  grp;
    phase_t      nxt_ph;
    b = in_data.data_byte;
    ev = EV_SKIP; kind = FK_NONE; val = {8'd0, b}; err = ER_NONE; fin = 1'b0;
    end_ok = 1'b0;
    grp = b[6:0]; nxt_ph = PH_TRAIL; nxt_field = FK_NONE;
    phase_next = phase; bytes_left_next = bytes_left; len_cnt_next = len_cnt;
    cur_type_next = cur_type; cur_flags_next = cur_flags; cflags_next = cflags;
    str_left_next = str_left; cur_field_next = cur_field; hi_hold_next = hi_hold;
    skip_cnt_next = skip_cnt; len_acc_next = len_acc;
    res = '0;
    if (in_data.packet_start || phase == PH_HDR ||
        (phase != PH_LEN && bytes_left == '0)) begin
      bytes_left_next = '0; len_cnt_next = '0; cflags_next = '0; str_left_next = '0;
      cur_field_next = FK_NONE; hi_hold_next = '0; skip_cnt_next = '0; len_acc_next = '0;
      cur_type_next = b[7:4]; cur_flags_next = b[3:0];
      res.packet_type = b[7:4]; res.packet_flags = b[3:0]; res.field_value = {8'd0, b};
      if (type_supported(b[7:4])) begin
        phase_next = PH_LEN; res.event_res = EV_HDR;
      end else begin
        phase_next = PH_HDR; res.event_res = EV_ERR; res.error_kind = ER_TYPE;
      end
    end else if (phase == PH_LEN) begin
      unique case (len_cnt[1:0])
        2'd0: len_acc_next = len_acc | {21'd0, grp};
        2'd1: len_acc_next = len_acc | {14'd0, grp, 7'd0};
        2'd2: len_acc_next = len_acc | {7'd0, grp, 14'd0};
        default: len_acc_next = len_acc | {grp, 21'd0};
      endcase
      len_cnt_next = len_cnt + 3'd1;
      res.packet_type = cur_type; res.packet_flags = cur_flags;
      res.remaining_length = len_acc_next; res.field_value = {8'd0, b};
      res.event_res = EV_LEN;
      if (b[7]) begin
        if (32'(len_cnt_next) >= MAX_LENGTH_BYTES) begin
          res.event_res = EV_ERR; res.error_kind = ER_LEN; phase_next = PH_HDR;
          cur_field_next = FK_NONE;
        end
      end else begin
        bytes_left_next = len_acc_next;
        if (cur_type == PT_CONNECT) begin
          skip_cnt_next = 4'(CONNECT_SKIP_BYTES); nxt_ph = PH_SKIP; nxt_field = FK_NONE;
        end else if (cur_type == PT_PUBLISH) begin
          nxt_ph = PH_HI; nxt_field = FK_TOPIC;
        end else if ((cur_type >= 4'd4 && cur_type <= 4'd8) || cur_type == PT_UNSUB) begin
          nxt_ph = PH_HI; nxt_field = FK_PID;
        end
        phase_next = nxt_ph; cur_field_next = nxt_field;
        if (len_acc_next == '0) begin
          end_ok = (nxt_ph == PH_TRAIL) ||
                   (nxt_ph == PH_HI && nxt_field == FK_TOPIC &&
                    (cur_type == PT_SUBSCRIBE || cur_type == PT_UNSUB));
          if (end_ok) res.packet_done = 1'b1;
          else begin res.event_res = EV_ERR; res.error_kind = ER_OVER; end
          phase_next = PH_HDR; cur_field_next = FK_NONE;
        end
      end
    end else begin
      bytes_left_next = bytes_left - 28'd1;
      nxt_ph = phase; nxt_field = cur_field;
      unique case (phase)
        PH_SKIP: begin
          ev = EV_SKIP; skip_cnt_next = skip_cnt - 4'd1;
          if (skip_cnt_next == '0) begin nxt_ph = PH_CFLAGS; nxt_field = FK_NONE; end
        end
        PH_CFLAGS: begin
          ev = EV_CFLAGS; cflags_next = b; nxt_ph = PH_HI; nxt_field = FK_KEEP;
        end
        PH_HI: begin
          ev = EV_HI; kind = cur_field; hi_hold_next = b; nxt_ph = PH_LO;
        end
        PH_LO: begin
          ev = EV_LO; kind = cur_field; val = {hi_hold, b};
          if (cur_field >= FK_CID && {12'd0, val} > bytes_left_next) err = ER_OVER;
          else if (cur_field >= FK_CID && val != '0) begin
            str_left_next = val; nxt_ph = PH_STR;
          end else fin = 1'b1;
        end
        PH_STR: begin
          ev = EV_STR; kind = cur_field; str_left_next = str_left - 16'd1;
          if (str_left_next == '0) fin = 1'b1;
        end
        PH_PAY: ev = EV_PAY;
        PH_QOS: begin ev = EV_QOS; nxt_ph = PH_HI; nxt_field = FK_TOPIC; end
        default: begin ev = EV_SKIP; nxt_ph = PH_TRAIL; nxt_field = FK_NONE; end
      endcase
      if (fin) begin
        nxt_ph = PH_HI; nxt_field = FK_NONE;
        case (cur_field)
          FK_KEEP: nxt_field = FK_CID;
          FK_CID: nxt_field = cflags[2] ? FK_WTOP : cflags[7] ? FK_USER :
                              cflags[6] ? FK_PASS : FK_NONE;
          FK_WTOP: nxt_field = FK_WMSG;
          FK_WMSG: nxt_field = cflags[7] ? FK_USER : cflags[6] ? FK_PASS : FK_NONE;
          FK_USER: nxt_field = cflags[6] ? FK_PASS : FK_NONE;
          FK_PID: begin
            if (cur_type == PT_PUBLISH) nxt_ph = PH_PAY;
            else if (cur_type == PT_SUBSCRIBE || cur_type == PT_UNSUB) nxt_field = FK_TOPIC;
          end
          FK_TOPIC: begin
            if (cur_type == PT_PUBLISH) begin
              if (cur_flags[2:1] != 2'd0) nxt_field = FK_PID;
              else nxt_ph = PH_PAY;
            end else if (cur_type == PT_SUBSCRIBE) nxt_ph = PH_QOS;
            else nxt_field = FK_TOPIC;
          end
          default: nxt_field = FK_NONE;
        endcase
        if (nxt_ph == PH_HI && nxt_field == FK_NONE) nxt_ph = PH_TRAIL;
      end
      phase_next = nxt_ph; cur_field_next = nxt_field;
      res.packet_type = cur_type; res.packet_flags = cur_flags;
      res.remaining_length = len_acc; res.field_value = val; res.field_kind = kind;
      res.event_res = ev;
      if (err != ER_NONE) begin
        res.event_res = EV_ERR; res.error_kind = err;
        phase_next = PH_HDR; cur_field_next = FK_NONE;
      end else if (bytes_left_next == '0) begin
        end_ok = (nxt_ph == PH_PAY) || (nxt_ph == PH_TRAIL) ||
                 (nxt_ph == PH_HI && nxt_field == FK_TOPIC &&
                  (cur_type == PT_SUBSCRIBE || cur_type == PT_UNSUB));
        if (end_ok) res.packet_done = 1'b1;
        else begin res.event_res = EV_ERR; res.error_kind = ER_OVER; end
        phase_next = PH_HDR; cur_field_next = FK_NONE;
      end
    end
  end

  `MQP_ASSERT_IMPL(a_err_kind, clk, rst, out_valid |-> ((out_data.event_res == EV_ERR) == (out_data.error_kind != ER_NONE)), "error kind without error event")
  `MQP_ASSERT_IMPL(a_err_hdr, clk, rst, (take && res.event_res == EV_ERR) |=> phase == PH_HDR, "no header expected after error")
  `MQP_ASSERT_IMPL(a_done_hdr, clk, rst, (take && res.packet_done) |=> phase == PH_HDR, "no header expected after packet end")
endmodule

### src/mqtt_control_packet_parser.sv
// A byte is registered into the two-entry queue; its result is registered into the back
// part's output register when the back part takes the byte from the queue.
// Throughput: one byte per cycle while out_ready does not stall the output register.
// Reset (rst, synchronous) empties the queue and sets the parser to expect a header.
// Depends on mqp_pkg, mqp_fifo, mqp_back.
module mqtt_control_packet_parser #(
  parameter int MAX_LENGTH_BYTES   = 4,
  parameter int CONNECT_SKIP_BYTES = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  mqp_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_ready,
  output mqp_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_ready
);
  import mqp_pkg::*;

  q_item_t q_wr, q_rd;
  logic    q_rd_valid, q_rd_ready;

  // front: register the item into the queue
  assign q_wr.data_byte    = in_data.data_byte;
  assign q_wr.packet_start = in_data.packet_start;

  mqp_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_data(q_wr), .wr_valid(in_valid), .wr_ready(in_ready),
    .rd_data(q_rd), .rd_valid(q_rd_valid), .rd_ready(q_rd_ready)
  );

  mqp_back #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES), .CONNECT_SKIP_BYTES(CONNECT_SKIP_BYTES)
  ) u_back (
    .clk(clk), .rst(rst), .in_data(q_rd), .in_valid(q_rd_valid), .in_ready(q_rd_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule

### tb/mqtt_control_packet_parser_tb.sv
// Testbench for the MQTT control packet parser: drives byte streams with random
// idling and compares every result item against an in-bench packet decoder.
// Depends on mqp_pkg and mqtt_control_packet_parser.
module mqtt_control_packet_parser_tb;
  import mqp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_item_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  out_item_t out_data;
  logic out_valid;
  logic out_ready = 1'b0;

  mqtt_control_packet_parser u_top (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder state
  phase_t      dphase = PH_HDR;
  logic [27:0] dleft = '0;
  int unsigned dlen_cnt = 0;
  logic [3:0]  dtype = '0, dflags = '0, dfield = FK_NONE;
  logic [7:0]  dcflags = '0, dhigh = '0;
  logic [15:0] dstr_left = '0;
  logic [3:0]  dskip = '0;
  logic [27:0] daccum = '0;

  in_item_t  pending_bytes[$];
  out_item_t expected_items[$];
  int        errors = 0;
  bit        quiet_tail = 0;
  bit        rx_hold = 0;
  int        rx_hold_cycles = 0;

  function automatic bit is_supported(logic [3:0] t);
    return t == 1 || t == 3 || (t >= 4 && t <= 8) || t == 10 || (t >= 12 && t <= 14);
  endfunction

  function automatic out_item_t make_item(logic [3:0] ev, logic [15:0] val,
                                          logic [3:0] kind, logic [1:0] err, logic done);
    out_item_t o;
    o.event_res = ev; o.packet_type = dtype; o.packet_flags = dflags;
    o.remaining_length = daccum; o.field_value = val; o.field_kind = kind;
    o.error_kind = err; o.packet_done = done;
    return o;
  endfunction

  task automatic decoder_clear();
    dphase = PH_HDR; dleft = '0; dlen_cnt = 0; dtype = '0; dflags = '0;
    dfield = FK_NONE; dcflags = '0; dhigh = '0; dstr_left = '0; dskip = '0; daccum = '0;
  endtask

  task automatic go_field(logic [3:0] k);
    dphase = PH_HI; dfield = k;
  endtask

  task automatic go_phase(phase_t p);
    dphase = p; dfield = FK_NONE;
  endtask

  task automatic after_user();
    if (dcflags[7]) go_field(FK_USER);
    else if (dcflags[6]) go_field(FK_PASS);
    else go_phase(PH_TRAIL);
  endtask

  task automatic next_field();
    case (dfield)
      FK_KEEP: go_field(FK_CID);
      FK_CID: if (dcflags[2]) go_field(FK_WTOP); else after_user();
      FK_WTOP: go_field(FK_WMSG);
      FK_WMSG: after_user();
      FK_USER: if (dcflags[6]) go_field(FK_PASS); else go_phase(PH_TRAIL);
      FK_PID: begin
        if (dtype == PT_PUBLISH) go_phase(PH_PAY);
        else if (dtype == PT_SUBSCRIBE || dtype == PT_UNSUB) go_field(FK_TOPIC);
        else go_phase(PH_TRAIL);
      end
      FK_TOPIC: begin
        if (dtype == PT_PUBLISH) begin
          if (dflags[2:1] != 0) go_field(FK_PID); else go_phase(PH_PAY);
        end else if (dtype == PT_SUBSCRIBE) go_phase(PH_QOS);
        else go_field(FK_TOPIC);
      end
      default: go_phase(PH_TRAIL);
    endcase
  endtask

  function automatic out_item_t close_packet(logic [3:0] ev, logic [15:0] val,
                                             logic [3:0] kind);
    bit ok;
    ok = dphase == PH_PAY || dphase == PH_TRAIL ||
         (dphase == PH_HI && dfield == FK_TOPIC &&
          (dtype == PT_SUBSCRIBE || dtype == PT_UNSUB));
    return ok ? make_item(ev, val, kind, ER_NONE, 1'b1) : make_item(EV_ERR, val, kind, ER_OVER, 1'b0);
  endfunction

  task automatic decode_byte(in_item_t it);
    logic [7:0] b;
    logic [3:0] ev, kind;
    logic [15:0] val;
    logic [1:0] err;
    out_item_t o;
    b = it.data_byte; ev = EV_SKIP; kind = FK_NONE; val = {8'd0, b}; err = ER_NONE;
    if (it.packet_start || dphase == PH_HDR || (dphase != PH_LEN && dleft == 0)) begin
      decoder_clear();
      dtype = b[7:4]; dflags = b[3:0];
      if (is_supported(dtype)) begin
        dphase = PH_LEN;
        expected_items.push_back(make_item(EV_HDR, val, FK_NONE, ER_NONE, 1'b0));
      end else
        expected_items.push_back(make_item(EV_ERR, val, FK_NONE, ER_TYPE, 1'b0));
      return;
    end
    if (dphase == PH_LEN) begin
      if (dlen_cnt < 4) daccum = daccum | (28'(b[6:0]) << (7 * dlen_cnt));
      dlen_cnt++;
      if (b[7]) begin
        if (dlen_cnt >= 4) begin
          expected_items.push_back(make_item(EV_ERR, val, FK_NONE, ER_LEN, 1'b0));
          go_phase(PH_HDR);
        end else
          expected_items.push_back(make_item(EV_LEN, val, FK_NONE, ER_NONE, 1'b0));
        return;
      end
      dleft = daccum;
      case (dtype)
        PT_CONNECT: begin dskip = 4'd7; go_phase(PH_SKIP); end
        PT_PUBLISH: go_field(FK_TOPIC);
        4, 5, 6, 7, 8, 10: go_field(FK_PID);
        default: go_phase(PH_TRAIL);
      endcase
      if (dleft == 0) begin
        o = close_packet(EV_LEN, val, FK_NONE);
        go_phase(PH_HDR);
      end else
        o = make_item(EV_LEN, val, FK_NONE, ER_NONE, 1'b0);
      expected_items.push_back(o);
      return;
    end
    dleft = dleft - 1;
    case (dphase)
      PH_SKIP: begin
        dskip = dskip - 1;
        if (dskip == 0) go_phase(PH_CFLAGS);
      end
      PH_CFLAGS: begin ev = EV_CFLAGS; dcflags = b; go_field(FK_KEEP); end
      PH_HI: begin ev = EV_HI; kind = dfield; dhigh = b; dphase = PH_LO; end
      PH_LO: begin
        ev = EV_LO; kind = dfield; val = {dhigh, b};
        if (dfield >= FK_CID) begin
          if (28'(val) > dleft) err = ER_OVER;
          else if (val > 0) begin dstr_left = val; dphase = PH_STR; end
          else next_field();
        end else next_field();
      end
      PH_STR: begin
        ev = EV_STR; kind = dfield; dstr_left = dstr_left - 1;
        if (dstr_left == 0) next_field();
      end
      PH_PAY: ev = EV_PAY;
      PH_QOS: begin ev = EV_QOS; go_field(FK_TOPIC); end
      default: go_phase(PH_TRAIL);
    endcase
    if (err != ER_NONE) begin
      o = make_item(EV_ERR, val, kind, err, 1'b0);
      go_phase(PH_HDR);
    end else if (dleft == 0) begin
      o = close_packet(ev, val, kind);
      go_phase(PH_HDR);
    end else
      o = make_item(ev, val, kind, ER_NONE, 1'b0);
    expected_items.push_back(o);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // driver
  int tx_idle = 0;
  bit in_took = 0;
  // note the input handshake as seen at the rising edge
  always @(posedge clk) in_took = in_valid && in_ready;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_took) decode_byte(in_data);
      if (!in_valid || in_took) begin
        if (tx_idle > 0) begin
          tx_idle--;
          in_valid <= 1'b0;
        end else if (!quiet_tail && pending_bytes.size() > 0 && $urandom_range(0, 9) == 0) begin
          tx_idle = $urandom_range(1, 4) - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_data <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else
          in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  int rx_idle = 0;
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      out_ready <= 1'b0;
    end else if (rx_idle > 0) begin
      rx_idle--;
      out_ready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      rx_idle = $urandom_range(1, 4) - 1;
      out_ready <= 1'b0;
    end else
      out_ready <= !rst;
  end

  // monitor
  always @(posedge clk) begin
    out_item_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_items.size() == 0) begin
        report_mismatch("unexpected item", out_data.event_res, 0);
      end else begin
        w = expected_items.pop_front();
        if (out_data.event_res !== w.event_res)
          report_mismatch("event_res", out_data.event_res, w.event_res);
        if (out_data.packet_type !== w.packet_type)
          report_mismatch("packet_type", out_data.packet_type, w.packet_type);
        if (out_data.packet_flags !== w.packet_flags)
          report_mismatch("packet_flags", out_data.packet_flags, w.packet_flags);
        if (out_data.remaining_length !== w.remaining_length)
          report_mismatch("remaining_length", out_data.remaining_length, w.remaining_length);
        if (out_data.field_value !== w.field_value)
          report_mismatch("field_value", out_data.field_value, w.field_value);
        if (out_data.field_kind !== w.field_kind)
          report_mismatch("field_kind", out_data.field_kind, w.field_kind);
        if (out_data.error_kind !== w.error_kind)
          report_mismatch("error_kind", out_data.error_kind, w.error_kind);
        if (out_data.packet_done !== w.packet_done)
          report_mismatch("packet_done", out_data.packet_done, w.packet_done);
      end
    end
  end

  task automatic put_byte(logic [7:0] b, bit st = 0);
    in_item_t it;
    it.data_byte = b; it.packet_start = st;
    pending_bytes.push_back(it);
  endtask

  task automatic put_len(int n);
    do begin
      put_byte({n > 127, 7'(n)});
      n = n >> 7;
    end while (n > 0);
  endtask

  task automatic put_str(int n);
    put_byte(8'(n >> 8)); put_byte(8'(n));
    repeat (n) put_byte(8'($urandom));
  endtask

  // well-formed packet of a random supported type, with random string sizes
  task automatic put_packet();
    int kind, a, c, d, e;
    logic [7:0] fl;
    kind = $urandom_range(0, 5);
    case (kind)
      0: begin
        fl = 8'($urandom) & 8'hC4;
        a = $urandom_range(0, 4); c = $urandom_range(0, 3); d = $urandom_range(0, 3);
        e = 10 + 2 + a + ((fl[2]) ? 4 + c + d : 0) + (fl[7] ? 2 + c : 0) + (fl[6] ? 2 + d : 0);
        put_byte({PT_CONNECT, 4'd0}, $urandom_range(0, 1)); put_len(e);
        repeat (7) put_byte(8'($urandom));
        put_byte(fl); put_byte(8'($urandom)); put_byte(8'($urandom)); put_str(a);
        if (fl[2]) begin put_str(c); put_str(d); end
        if (fl[7]) put_str(c);
        if (fl[6]) put_str(d);
      end
      1: begin
        fl = 8'($urandom_range(0, 15)); a = $urandom_range(0, 5); c = $urandom_range(0, 6);
        put_byte({PT_PUBLISH, fl[3:0]}); put_len(2 + a + (fl[2:1] != 0 ? 2 : 0) + c);
        put_str(a);
        if (fl[2:1] != 0) begin put_byte(8'($urandom)); put_byte(8'($urandom)); end
        repeat (c) put_byte(8'($urandom));
      end
      2: begin
        c = $urandom_range(0, 3); a = $urandom_range(0, 3);
        put_byte({PT_SUBSCRIBE, 4'd2}); put_len(2 + c * (3 + a));
        put_byte(8'($urandom)); put_byte(8'($urandom));
        repeat (c) begin put_str(a); put_byte(8'($urandom_range(0, 2))); end
      end
      3: begin
        c = $urandom_range(0, 3); a = $urandom_range(0, 3);
        put_byte({PT_UNSUB, 4'd2}); put_len(2 + c * (2 + a));
        put_byte(8'($urandom)); put_byte(8'($urandom));
        repeat (c) put_str(a);
      end
      4: begin
        put_byte({4'($urandom_range(4, 7)), 4'($urandom)}); put_len(2);
        put_byte(8'($urandom)); put_byte(8'($urandom));
      end
      default: begin
        put_byte({4'($urandom_range(12, 14)), 4'($urandom)}); put_len(0);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_valid || expected_items.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed: unsupported types, overlong and maximum lengths, overruns, short ends
    put_byte(8'h00); put_byte(8'h2F); put_byte(8'h9A); put_byte(8'hB0); put_byte(8'hFF);
    put_byte(8'h30); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF);
    put_byte(8'h30); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'hFF); put_byte(8'h7F);
    put_byte(8'h00, 1);
    put_byte(8'h30); put_len(3); put_byte(8'h00); put_byte(8'h05); put_byte(8'h41);
    put_byte(8'h40); put_len(1); put_byte(8'h12);
    put_byte(8'h82); put_len(0);
    put_byte(8'hC0); put_len(2); put_byte(8'h00); put_byte(8'h80);
    put_byte(8'hE0); put_len(0);
    wait_drained();
    for (int i = 0; i < 100; i++) begin
      if (i == 40) begin
        // long receiver hold while bytes keep coming
        rx_hold_cycles = 60;
        repeat (40) put_packet();
        wait_drained();
      end
      if (i >= 80) quiet_tail = 1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else
        put_packet();
      while (pending_bytes.size() > 16) @(posedge clk);
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_items.size() == 0)
      $display("[mqtt_control_packet_parser] OK");
    else
      $display("[mqtt_control_packet_parser] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[mqtt_control_packet_parser] ERROR");
    $finish;
  end

endmodule
